>>> src/sgm_pkg.sv
// ============================================================================
// sgm_pkg
// Shared types and constants for the Sobel gradient magnitude block.
// ============================================================================
`default_nettype none

package sgm_pkg;

    // Configuration port
    localparam int CFG_W = 13;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_GREY   = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic             GREY_RESET   = 1'b0;

    // Geometry limits
    localparam int MIN_WIDTH  = 3;
    localparam int MAX_WIDTH  = 4096;
    localparam int MIN_HEIGHT = 3;

    // Result fields
    localparam int POS_W = 26;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Kernel arithmetic: |dx|+|dy| fits 11 bits, divide by 3 via 683/2048
    localparam int               SUM_W       = 11;
    localparam logic [SUM_W-1:0] RECIP_3     = 11'd683;
    localparam int               RECIP_SHIFT = 11;
    localparam logic [7:0]       GRAD_MAX    = 8'd255;

    typedef logic [7:0] byte_t;

    // One kernel job: 3x3 window, win[col*3 + row], col 0 left, row 0 top
    typedef struct packed {
        byte_t [8:0]      win;
        logic [POS_W-1:0] position;
        logic             frame_end;
    } job_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic              valid;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

`default_nettype wire

>>> src/sgm_ifs.sv
// ============================================================================
// sgm_ifs
// Valid/ready stream interfaces for image bytes and gradient results.
// ============================================================================
`default_nettype none

interface sgm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface sgm_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  gradient;
    logic [25:0] position;
    logic        frame_end;

    modport source (output valid, output gradient, output position, output frame_end,
                    input ready);
    modport sink   (input valid, input gradient, input position, input frame_end,
                    output ready);
endinterface

`default_nettype wire

>>> src/sgm_front.sv
// ============================================================================
// sgm_front
// Accepts image bytes, keeps the line stores and window, issues kernel jobs.
// ============================================================================
`default_nettype none

module sgm_front #(
    parameter int MAX_ROW_BYTES = 16384,
    parameter int MAX_ROWS      = 4096
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    sgm_in_if.sink                          feed,
    input  wire logic                       wr_en,
    input  wire logic [sgm_pkg::IDX_W-1:0]  wr_index,
    input  wire logic [sgm_pkg::CFG_W-1:0]  wr_data,
    input  wire sgm_pkg::q_status_t         q_stat,
    output logic                            job_push,
    output sgm_pkg::job_t                   job
);

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int HW = $clog2(MAX_ROWS);
    localparam int GW = 17;
    localparam int PW = sgm_pkg::POS_W;

    // Configuration registers
    logic [sgm_pkg::CFG_W-1:0] width_reg;
    logic [sgm_pkg::CFG_W-1:0] height_reg;
    logic                      grey_reg;

    // Frame position and window state
    logic [AW-1:0]           col_reg, col_next;
    logic [HW-1:0]           row_reg, row_next;
    logic [PW-1:0]           count_reg, count_next;
    sgm_pkg::byte_t [5:0]    win_reg, win_next;
    logic                    tail_pend_reg, tail_pend_next;
    sgm_pkg::byte_t [5:0]    tail_cols_reg;
    logic [PW-1:0]           tail_pos_reg;

    // Line stores and their prefetched read data
    sgm_pkg::byte_t store_a [MAX_ROW_BYTES];
    sgm_pkg::byte_t store_b [MAX_ROW_BYTES];
    sgm_pkg::byte_t rd_a_reg, rd_b_reg;

    logic [GW-1:0]        w_ext, w_clamp, w_x3, r_full, h_ext, h_clamp;
    logic [AW-1:0]        col_last, col_step, rd_addr;
    logic [HW-1:0]        row_last;
    logic [PW-1:0]        r_pos;
    logic                 take, restart, col_wrap, at_last, emit1;
    sgm_pkg::byte_t       tap_a, tap_b;
    sgm_pkg::byte_t [5:0] shifted;

    // Derive row length and last row from the registers
    always_comb
    begin
        w_ext   = GW'(width_reg);
        w_clamp = (w_ext < GW'(sgm_pkg::MIN_WIDTH)) ? GW'(sgm_pkg::MIN_WIDTH) :
                  (w_ext > GW'(sgm_pkg::MAX_WIDTH)) ? GW'(sgm_pkg::MAX_WIDTH) : w_ext;
        w_x3    = grey_reg ? w_clamp : w_clamp + (w_clamp << 1);
        r_full  = (w_x3 > GW'(MAX_ROW_BYTES)) ? GW'(MAX_ROW_BYTES) : w_x3;
        h_ext   = GW'(height_reg);
        h_clamp = (h_ext < GW'(sgm_pkg::MIN_HEIGHT)) ? GW'(sgm_pkg::MIN_HEIGHT) :
                  (h_ext > GW'(MAX_ROWS)) ? GW'(MAX_ROWS) : h_ext;
        col_last = AW'(r_full - 1'b1);
        row_last = HW'(h_clamp - 1'b1);
        r_pos    = PW'(r_full);
    end

    // Hold off new bytes unless the queue has room for a job and a tail job
    assign feed.ready = (q_stat.count <= sgm_pkg::QCNT_W'(sgm_pkg::QUEUE_DEPTH - 2));
    assign take       = feed.valid && feed.ready;
    assign restart    = wr_en && (wr_index == sgm_pkg::REG_WIDTH ||
                                  wr_index == sgm_pkg::REG_HEIGHT ||
                                  wr_index == sgm_pkg::REG_GREY);

    // Classify the byte and build the shifted window
    always_comb
    begin
        col_wrap = (col_reg == col_last);
        col_step = col_wrap ? '0 : col_reg + 1'b1;
        at_last  = (row_reg == row_last) && col_wrap;
        emit1    = (row_reg > HW'(2)) || (row_reg == HW'(2) && col_reg != '0);
        tap_a    = (row_reg != '0) ? rd_a_reg : '0;
        tap_b    = (row_reg >= HW'(2)) ? rd_b_reg : '0;
        rd_addr  = take ? col_step : col_reg;

        shifted[2:0] = win_reg[5:3];
        shifted[3]   = tap_b;
        shifted[4]   = tap_a;
        shifted[5]   = feed.sample;
    end

    // Advance frame counters, clear on frame end or a write to a known register
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        count_next     = count_reg;
        win_next       = win_reg;
        tail_pend_next = take && at_last;
        priority if (restart)
        begin
            col_next   = '0;
            row_next   = '0;
            count_next = '0;
            win_next   = '0;
        end
        else if (take)
        begin
            if (at_last)
            begin
                col_next   = '0;
                row_next   = '0;
                count_next = '0;
                win_next   = '0;
            end
            else
            begin
                win_next   = shifted;
                count_next = count_reg + 1'b1;
                col_next   = col_step;
                if (col_wrap)
                begin
                    row_next = row_reg + 1'b1;
                end
            end
        end
        else
        begin
            // hold position while no byte arrives
            col_next = col_reg;
        end
    end

    // Issue the tail job of the previous frame, else the job of this byte
    always_comb
    begin
        job_push = tail_pend_reg || (take && emit1);
        if (tail_pend_reg)
        begin
            job.win[5:0]  = tail_cols_reg;
            job.win[6]    = rd_b_reg;
            job.win[7]    = rd_a_reg;
            job.win[8]    = '0;
            job.position  = tail_pos_reg;
            job.frame_end = 1'b1;
        end
        else
        begin
            job.win[5:0]  = win_reg;
            job.win[6]    = tap_b;
            job.win[7]    = tap_a;
            job.win[8]    = feed.sample;
            job.position  = count_reg - r_pos - 1'b1;
            job.frame_end = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= sgm_pkg::WIDTH_RESET;
            height_reg    <= sgm_pkg::HEIGHT_RESET;
            grey_reg      <= sgm_pkg::GREY_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            count_reg     <= '0;
            win_reg       <= '0;
            tail_pend_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    sgm_pkg::REG_WIDTH:  width_reg  <= wr_data;
                    sgm_pkg::REG_HEIGHT: height_reg <= wr_data;
                    sgm_pkg::REG_GREY:   grey_reg   <= wr_data[0];
                    default: ;
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            count_reg     <= count_next;
            win_reg       <= win_next;
            tail_pend_reg <= tail_pend_next;
        end
    end

    // Capture the two left columns and position of the tail job
    always_ff @(posedge clk)
    begin
        if (take && at_last)
        begin
            tail_cols_reg <= shifted;
            tail_pos_reg  <= count_reg - r_pos;
        end
    end

    // Line stores: write this column, prefetch the next one
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            store_a[col_reg] <= feed.sample;
            store_b[col_reg] <= tap_a;
        end
        rd_a_reg <= store_a[rd_addr];
        rd_b_reg <= store_b[rd_addr];
    end

endmodule

`default_nettype wire

>>> src/sgm_queue.sv
// ============================================================================
// sgm_queue
// Short job queue decoupling the byte front from the kernel back.
// ============================================================================
`default_nettype none

module sgm_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire sgm_pkg::job_t      push_job,
    input  wire logic               pop,
    output sgm_pkg::q_status_t      stat,
    output sgm_pkg::job_t           head
);

    sgm_pkg::job_t                   slots [sgm_pkg::QUEUE_DEPTH];
    logic [sgm_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [sgm_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign stat.valid = (count_reg != '0);
    assign stat.count = count_reg;
    assign head       = slots[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> src/sgm_back.sv
// ============================================================================
// sgm_back
// Sobel kernel: |dx|+|dy| stage, divide by 3 and saturate into the output.
// ============================================================================
`default_nettype none

module sgm_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sgm_pkg::q_status_t q_stat,
    input  wire sgm_pkg::job_t      head,
    output logic                    pop,
    sgm_out_if.source               result
);

    localparam int SW = sgm_pkg::SUM_W;
    localparam int PW = sgm_pkg::POS_W;

    logic          s1_valid_reg, s1_valid_next;
    logic [SW-1:0] sum_reg;
    logic [PW-1:0] pos1_reg;
    logic          end1_reg;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    grad_reg;
    logic [PW-1:0] pos_out_reg;
    logic          end_out_reg;

    logic          out_move, s1_move, s1_load;
    logic [SW-1:0] px, nx, py, ny, adx, ady, sum;
    logic [2*SW-1:0] prod;
    logic [SW-1:0] quot;
    logic [7:0]    grad;

    // Pipeline handshake
    assign out_move = !out_valid_reg || result.ready;
    assign s1_move  = s1_valid_reg && out_move;
    assign s1_load  = !s1_valid_reg || out_move;
    assign pop      = q_stat.valid && s1_load;

    // Kernel sums and absolute differences
    always_comb
    begin
        px  = (SW'(head.win[7]) << 1) + SW'(head.win[6]) + SW'(head.win[8]);
        nx  = (SW'(head.win[1]) << 1) + SW'(head.win[0]) + SW'(head.win[2]);
        py  = (SW'(head.win[3]) << 1) + SW'(head.win[0]) + SW'(head.win[6]);
        ny  = (SW'(head.win[5]) << 1) + SW'(head.win[2]) + SW'(head.win[8]);
        adx = (px >= nx) ? px - nx : nx - px;
        ady = (py >= ny) ? py - ny : ny - py;
        sum = adx + ady;
    end

    // Divide by 3 through the reciprocal, saturate to a byte
    always_comb
    begin
        prod = (2*SW)'(sum_reg) * (2*SW)'(sgm_pkg::RECIP_3);
        quot = prod[2*SW-1:sgm_pkg::RECIP_SHIFT];
        grad = (quot > SW'(sgm_pkg::GRAD_MAX)) ? sgm_pkg::GRAD_MAX : quot[7:0];
    end

    // Stage valid flags
    always_comb
    begin
        s1_valid_next  = pop ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sum_reg  <= sum;
            pos1_reg <= head.position;
            end1_reg <= head.frame_end;
        end
        if (s1_move)
        begin
            grad_reg    <= grad;
            pos_out_reg <= pos1_reg;
            end_out_reg <= end1_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.gradient  = grad_reg;
    assign result.position  = pos_out_reg;
    assign result.frame_end = end_out_reg;

endmodule

`default_nettype wire

>>> src/sobel_gradient_magnitude.sv
// ============================================================================
// sobel_gradient_magnitude
// Sobel 3x3 gradient magnitude over a raster byte stream, line buffered.
// ============================================================================
// Usage:
//   feed carries image bytes in raster order, one word per handshake. A row is
//   width bytes in grey mode, three times width in colour mode. result carries
//   (|dx|+|dy|)/3 saturated at 255, the byte index of the centre and a
//   frame_end flag on the last result of each frame.
//   The write port (wr_en, wr_index, wr_data) sets width, height and grey mode;
//   each such write restarts the frame. Write only while no word is in flight.
// Throughput: one byte per cycle while feed.ready is high; the two line stores
//   are single memories written at the current column, read one column ahead.
// Path: a job passes the queue, the sum register and the output register;
//   the final byte of a frame also queues a tail job with a second result.
// Reset: registers return to 640 x 480 colour, the frame counter and window
//   clear; line store contents are left as they are and read as zero until
//   the frame has filled them.
// Stall: a stalled receiver holds the output register; the back pipeline
//   fills and once the queue holds three jobs feed.ready drops until space
//   frees up, keeping the fourth slot for the tail result of a frame.
// ============================================================================
`default_nettype none

module sobel_gradient_magnitude #(
    parameter int MAX_ROW_BYTES = 16384,
    parameter int MAX_ROWS      = 4096
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    sgm_in_if.sink                         feed,
    sgm_out_if.source                      result,
    input  wire logic                      wr_en,
    input  wire logic [sgm_pkg::IDX_W-1:0] wr_index,
    input  wire logic [sgm_pkg::CFG_W-1:0] wr_data
);

    logic               q_push;
    logic               q_pop;
    sgm_pkg::job_t      q_in_job;
    sgm_pkg::job_t      q_head;
    sgm_pkg::q_status_t q_stat;

    // Front: byte intake, line stores, window
    sgm_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .feed     (feed),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .q_stat   (q_stat),
        .job_push (q_push),
        .job      (q_in_job)
    );

    // Job queue
    sgm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in_job),
        .pop      (q_pop),
        .stat     (q_stat),
        .head     (q_head)
    );

    // Back: kernel and output register
    sgm_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (q_head),
        .pop    (q_pop),
        .result (result)
    );

    // Queue never overflows
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_stat.count != sgm_pkg::QCNT_W'(sgm_pkg::QUEUE_DEPTH)))
        else $error("job queue overflow");

    // Back never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.valid)
        else $error("job queue underflow");

    // Two frame ends never follow each other
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.frame_end)
            |=> !(result.valid && result.frame_end))
        else $error("back-to-back frame_end results");

endmodule

`default_nettype wire

>>> tb/sv/gradient_checker.sv
// ============================================================================
// gradient_checker
// Watches the feed, result and register write ports of the Sobel block,
// keeps its own line stores and window, and checks every result word
// against the gradient predicted for it, field by field and in order.
// ============================================================================

module gradient_checker #(
    parameter int MAX_ROW_BYTES = 16384,
    parameter int MAX_ROWS      = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    sgm_in_if                                  feed,
    sgm_out_if                                 result,
    input  logic                               wr_en,
    input  logic [sgm_pkg::IDX_W-1:0]          wr_index,
    input  logic [sgm_pkg::CFG_W-1:0]          wr_data,
    output int                                 pending,
    output int                                 fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        sgm_pkg::byte_t            gradient;
        logic [sgm_pkg::POS_W-1:0] position;
        logic                      frame_end;
    } grad_t;

    grad_t                     expected_grads[$];
    sgm_pkg::byte_t            row_a[MAX_ROW_BYTES];
    sgm_pkg::byte_t            row_b[MAX_ROW_BYTES];
    sgm_pkg::byte_t            prev_cols[6];
    int unsigned               frame_pos;
    logic [sgm_pkg::CFG_W-1:0] width_px;
    logic [sgm_pkg::CFG_W-1:0] height_px;
    logic                      grey;

    // Row length in bytes after saturating the geometry
    function automatic int unsigned row_len();
        int unsigned w;
        w = width_px;
        if (w < sgm_pkg::MIN_WIDTH) w = sgm_pkg::MIN_WIDTH;
        if (w > sgm_pkg::MAX_WIDTH) w = sgm_pkg::MAX_WIDTH;
        if (!grey) w = 3 * w;
        if (w > MAX_ROW_BYTES) w = MAX_ROW_BYTES;
        return w;
    endfunction

    function automatic int unsigned row_count();
        int unsigned h;
        h = height_px;
        if (h < sgm_pkg::MIN_HEIGHT) h = sgm_pkg::MIN_HEIGHT;
        if (h > MAX_ROWS) h = MAX_ROWS;
        return h;
    endfunction

    // Window is w[col*3 + row]: col 0 left, row 0 top
    function automatic sgm_pkg::byte_t kernel_mag(input sgm_pkg::byte_t w[9]);
        int t[9];
        int dx;
        int dy;
        int g;
        foreach (t[i]) t[i] = w[i];
        dx = 2 * t[7] + t[6] + t[8] - 2 * t[1] - t[0] - t[2];
        dy = t[0] + 2 * t[3] + t[6] - t[2] - 2 * t[5] - t[8];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        g = (dx + dy) / 3;
        if (g > sgm_pkg::GRAD_MAX) g = sgm_pkg::GRAD_MAX;
        return sgm_pkg::byte_t'(g);
    endfunction

    task automatic restart_frame();
        frame_pos = 0;
        foreach (prev_cols[i]) prev_cols[i] = '0;
    endtask

    // Advance the line stores and window by one byte and queue its gradients
    task automatic predict_gradients(input sgm_pkg::byte_t s);
        int unsigned    r;
        int unsigned    total;
        int unsigned    n;
        int unsigned    p;
        int unsigned    q;
        sgm_pkg::byte_t a;
        sgm_pkg::byte_t b;
        sgm_pkg::byte_t w[9];
        r     = row_len();
        total = r * row_count();
        n     = frame_pos;
        p     = n % r;
        // line store taps read as zero until this frame has filled them
        a = (n >= r) ? row_a[p] : '0;
        b = (n >= 2 * r) ? row_b[p] : '0;
        row_b[p] = a;
        row_a[p] = s;
        for (int i = 0; i < 6; i++) w[i] = prev_cols[i];
        w[6] = b;
        w[7] = a;
        w[8] = s;
        for (int i = 0; i < 6; i++) prev_cols[i] = w[i + 3];
        if (n >= 2 * r + 1)
            expected_grads.push_back('{kernel_mag(w), sgm_pkg::POS_W'(n - r - 1), 1'b0});
        // last byte: flush the final centre with the tap past the image at zero
        if (n + 1 >= total)
        begin
            q = (n + 1) % r;
            for (int i = 0; i < 6; i++) w[i] = prev_cols[i];
            w[6] = row_b[q];
            w[7] = row_a[q];
            w[8] = '0;
            expected_grads.push_back('{kernel_mag(w), sgm_pkg::POS_W'(n - r), 1'b1});
            restart_frame();
        end
        else
        begin
            frame_pos = n + 1;
        end
    endtask

    // Any write to a known register restarts the frame; a spare index is dropped
    task automatic apply_write();
        case (wr_index)
            sgm_pkg::REG_WIDTH:
            begin
                width_px = wr_data;
                restart_frame();
            end
            sgm_pkg::REG_HEIGHT:
            begin
                height_px = wr_data;
                restart_frame();
            end
            sgm_pkg::REG_GREY:
            begin
                grey = wr_data[0];
                restart_frame();
            end
            default: ;
        endcase
    endtask

    task automatic check_gradient();
        grad_t want;
        if (expected_grads.size() == 0)
        begin
            $error("unexpected result word: gradient %0d position %0d frame_end %0d",
                   result.gradient, result.position, result.frame_end);
            fail_count++;
        end
        else
        begin
            want = expected_grads.pop_front();
            if (result.gradient !== want.gradient)
            begin
                $error("gradient: expected %0d, got %0d", want.gradient, result.gradient);
                fail_count++;
            end
            if (result.position !== want.position)
            begin
                $error("position: expected %0d, got %0d", want.position, result.position);
                fail_count++;
            end
            if (result.frame_end !== want.frame_end)
            begin
                $error("frame_end: expected %0d, got %0d", want.frame_end, result.frame_end);
                fail_count++;
            end
        end
    endtask

    // Sample all ports at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_grads.delete();
            width_px   = sgm_pkg::WIDTH_RESET;
            height_px  = sgm_pkg::HEIGHT_RESET;
            grey       = sgm_pkg::GREY_RESET;
            restart_frame();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (result.valid && result.ready) check_gradient();
            if (wr_en) apply_write();
            if (feed.valid && feed.ready) predict_gradients(feed.sample);
            pending <= expected_grads.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// ============================================================================
// testbench
// Drives image frames of many geometries into the Sobel gradient block:
// a few hand-made 3x3 frames with extreme bytes, register writes mid-frame,
// then random frames under three idling profiles and a short abandoned
// frame at the largest row and row-count settings. The checker predicts
// every result.
// ============================================================================

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                        MAX_ROW_BYTES   = 16384;
    localparam int                        MAX_ROWS        = 4096;
    localparam logic [sgm_pkg::IDX_W-1:0] REG_SPARE       = 2'd3;
    localparam int                        SETTLE_CYCLES   = 8;
    localparam int                        CYCLE_LIMIT     = 1_000_000;
    localparam int                        ITEMS_PER_PHASE = 410;
    localparam int                        LARGE_BYTES     = 64;

    logic                      clk;
    logic                      rst_n;
    logic                      wr_en;
    logic [sgm_pkg::IDX_W-1:0] wr_index;
    logic [sgm_pkg::CFG_W-1:0] wr_data;
    int                        pending;
    int                        fail_count;
    int                        cycles = 0;
    int                        tx_idle = 8;
    int                        rx_idle = 75;
    int                        sent = 0;
    logic [sgm_pkg::CFG_W-1:0] cur_width;
    logic [sgm_pkg::CFG_W-1:0] cur_height;
    logic                      cur_grey;

    sgm_pkg::byte_t stripes[9]  = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
                                    8'hFF, 8'h00};
    sgm_pkg::byte_t step_row[9] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                                    8'h00, 8'h00};

    sgm_in_if  feed();
    sgm_out_if result();

    sobel_gradient_magnitude #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .feed     (feed),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    gradient_checker #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS)
    ) grad_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed       (feed),
        .result     (result),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        result.ready <= ($urandom_range(99) >= rx_idle);
    end

    // Bytes in one whole frame at the current geometry
    function automatic int frame_bytes();
        int w;
        int h;
        w = cur_width;
        h = cur_height;
        if (w < sgm_pkg::MIN_WIDTH) w = sgm_pkg::MIN_WIDTH;
        if (w > sgm_pkg::MAX_WIDTH) w = sgm_pkg::MAX_WIDTH;
        if (!cur_grey) w = 3 * w;
        if (w > MAX_ROW_BYTES) w = MAX_ROW_BYTES;
        if (h < sgm_pkg::MIN_HEIGHT) h = sgm_pkg::MIN_HEIGHT;
        if (h > MAX_ROWS) h = MAX_ROWS;
        return w * h;
    endfunction

    // Offer one word, idling first at random, and hold it until taken
    task automatic push_byte(input sgm_pkg::byte_t value);
        while ($urandom_range(99) < tx_idle)
        begin
            feed.valid <= 1'b0;
            @(posedge clk);
        end
        feed.valid  <= 1'b1;
        feed.sample <= value;
        do @(posedge clk); while (!feed.ready);
        sent++;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) push_byte(sgm_pkg::byte_t'($urandom_range(255)));
    endtask

    // Drop valid and wait until every predicted word is back and the pipe is empty
    task automatic drain();
        feed.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sgm_pkg::IDX_W-1:0] index,
                             input logic [sgm_pkg::CFG_W-1:0] value);
        drain();
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= value;
        @(posedge clk);
        wr_en    <= 1'b0;
        case (index)
            sgm_pkg::REG_WIDTH:  cur_width  = value;
            sgm_pkg::REG_HEIGHT: cur_height = value;
            sgm_pkg::REG_GREY:   cur_grey   = value[0];
            default: ;
        endcase
    endtask

    // One small frame of random bytes, sometimes cut short or interrupted
    task automatic random_frame();
        int total;
        int cut;
        int pick;
        if ($urandom_range(1))
            write_reg(sgm_pkg::REG_WIDTH,
                      ($urandom_range(9) == 0) ? sgm_pkg::CFG_W'($urandom_range(2))
                                               : sgm_pkg::CFG_W'($urandom_range(3, 8)));
        if ($urandom_range(1))
            write_reg(sgm_pkg::REG_HEIGHT,
                      ($urandom_range(9) == 0) ? sgm_pkg::CFG_W'($urandom_range(2))
                                               : sgm_pkg::CFG_W'($urandom_range(3, 6)));
        if ($urandom_range(2) == 0)
            write_reg(sgm_pkg::REG_GREY, sgm_pkg::CFG_W'($urandom_range(1)));
        total = frame_bytes();
        pick  = $urandom_range(9);
        cut   = (pick < 2) ? $urandom_range(1, total - 1) : total;
        send_random(cut);
        if (pick == 0)
        begin
            // abandon the frame: rewriting width, height or grey restarts it
            case ($urandom_range(2))
                0:       write_reg(sgm_pkg::REG_WIDTH, cur_width);
                1:       write_reg(sgm_pkg::REG_HEIGHT, cur_height);
                default: write_reg(sgm_pkg::REG_GREY, sgm_pkg::CFG_W'(cur_grey));
            endcase
        end
        else if (pick == 1)
        begin
            // spare index must leave the frame running
            write_reg(REG_SPARE, sgm_pkg::CFG_W'($urandom_range(8191)));
            send_random(total - cut);
        end
    endtask

    initial
    begin
        int goal;
        rst_n        <= 1'b0;
        wr_en        <= 1'b0;
        wr_index     <= '0;
        wr_data      <= '0;
        feed.valid   <= 1'b0;
        feed.sample  <= '0;
        cur_width  = sgm_pkg::WIDTH_RESET;
        cur_height = sgm_pkg::HEIGHT_RESET;
        cur_grey   = sgm_pkg::GREY_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest grey frame with alternating extremes, then a hard edge
        write_reg(sgm_pkg::REG_GREY, sgm_pkg::CFG_W'(1));
        write_reg(sgm_pkg::REG_WIDTH, 13'd3);
        write_reg(sgm_pkg::REG_HEIGHT, 13'd3);
        for (int i = 0; i < 9; i++) push_byte(stripes[i]);
        for (int i = 0; i < 3; i++) push_byte(step_row[i]);
        write_reg(REG_SPARE, 13'h1FFF);
        for (int i = 3; i < 9; i++) push_byte(step_row[i]);
        // Partial frame dropped by a register write
        for (int i = 0; i < 4; i++) push_byte(stripes[8 - i]);
        write_reg(sgm_pkg::REG_WIDTH, 13'd3);

        // Random frames under each idling profile
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle = 8;
                    rx_idle = 75;
                end
                1:
                begin
                    tx_idle = 75;
                    rx_idle = 8;
                end
                default:
                begin
                    tx_idle = 0;
                    rx_idle = 0;
                end
            endcase
            goal = sent + ITEMS_PER_PHASE;
            while (sent < goal) random_frame();
        end

        // Largest colour geometry: a short start of frame, then abandon it
        write_reg(sgm_pkg::REG_GREY, sgm_pkg::CFG_W'(0));
        write_reg(sgm_pkg::REG_WIDTH, 13'h1FFF);
        write_reg(sgm_pkg::REG_HEIGHT, 13'h1FFF);
        send_random(LARGE_BYTES);
        write_reg(sgm_pkg::REG_WIDTH, 13'd3);

        drain();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
